### hw/rtl/fuzzy_process_state_scheduler_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fuzzy process state scheduler
// Clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef FUZZY_PROCESS_STATE_SCHEDULER_MACROS_SVH
`define FUZZY_PROCESS_STATE_SCHEDULER_MACROS_SVH

// same-cycle implication
`define FPSS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FPSS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/fpss_pkg.sv
// ----------------------------------------------------------------------------
// fpss_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package fpss_pkg;

  localparam int SLOTS_DEFAULT       = 16;
  localparam int HISTORY_LEN_DEFAULT = 10;

  localparam int QW = 17;
  localparam logic [QW-1:0] Q_ONE  = 17'd65536;
  localparam logic [QW-1:0] Q_HALF = 17'd32768;

  localparam logic [1:0] OP_ACTIVATE = 2'd0;
  localparam logic [1:0] OP_TICK     = 2'd1;
  localparam logic [1:0] OP_RETIRE   = 2'd2;

  localparam logic [2:0] REG_BASE_PROB    = 3'd0;
  localparam logic [2:0] REG_RUN_PRIO     = 3'd1;
  localparam logic [2:0] REG_GAIN_INPUT   = 3'd2;
  localparam logic [2:0] REG_GAIN_DECAY   = 3'd3;
  localparam logic [2:0] REG_GAIN_CONTEXT = 3'd4;
  localparam logic [2:0] REG_FUZZ_FLOOR   = 3'd5;
  localparam logic [2:0] REG_TIME_STEP    = 3'd6;

  localparam logic [QW-1:0] RST_BASE_PROB    = 17'd32768;
  localparam logic [QW-1:0] RST_RUN_PRIO     = 17'd32768;
  localparam logic [QW-1:0] RST_GAIN_INPUT   = 17'd52429;
  localparam logic [QW-1:0] RST_GAIN_DECAY   = 17'd6554;
  localparam logic [QW-1:0] RST_GAIN_CONTEXT = 17'd19661;
  localparam logic [QW-1:0] RST_FUZZ_FLOOR   = 17'd6554;
  localparam logic [QW-1:0] RST_TIME_STEP    = 17'd66;

  typedef struct packed {
    logic load;
    logic clr;
    logic mul1;
    logic mul2;
    logic sum;
    logic muldt;
    logic lvl;
    logic total;
    logic div;
    logic fin_tick;
    logic fin_other;
  } fpss_cmd_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic       in_range;
    logic       active;
    logic       clr_last;
  } fpss_stat_t;

  function automatic logic [QW-1:0] q_sat(input logic [QW-1:0] v);
    return (v > Q_ONE) ? Q_ONE : v;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fuzzy_process_state_scheduler.sv
// ----------------------------------------------------------------------------
// fuzzy_process_state_scheduler
// Per-slot fuzzy level table with history-mean context and thresholded
// decision, in unsigned Q16 fixed point.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Every item gives one
// result, shown for a single cycle with done_o high; the receiver cannot stall,
// so capture it in that cycle. A tick on an active slot runs through eight
// controller steps (one step per multiply stage, the sum, the clamp, the
// history read-modify-write and the reciprocal divide by the history length),
// and no new item is taken until it ends, with the strobe in the cycle after
// the last step; activate, retire and all other items end at the fetch step.
// After reset the slot store is cleared one slot a cycle with busy high;
// configuration writes are taken at any time.
`default_nettype none
`include "fuzzy_process_state_scheduler_macros.svh"

module fuzzy_process_state_scheduler #(
  parameter int SLOTS       = fpss_pkg::SLOTS_DEFAULT,
  parameter int HISTORY_LEN = fpss_pkg::HISTORY_LEN_DEFAULT
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [3:0]  slot_i,
  input  wire logic [9:0]  random_draw_i,
  input  wire logic        task_running_i,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [16:0] cfg_data_i,
  output logic             done_o,
  output logic [3:0]       slot_out_o,
  output logic             decided_o,
  output logic             boosted_o,
  output logic [6:0]       new_priority_o,
  output logic [16:0]      level_o,
  output logic [16:0]      context_level_o
);

  fpss_pkg::fpss_cmd_t  cmd;
  fpss_pkg::fpss_stat_t stat;

  fpss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  fpss_dp #(
    .SLOTS       (SLOTS),
    .HISTORY_LEN (HISTORY_LEN)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .opcode_i        (opcode_i),
    .slot_i          (slot_i),
    .random_draw_i   (random_draw_i),
    .task_running_i  (task_running_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .done_o          (done_o),
    .slot_out_o      (slot_out_o),
    .decided_o       (decided_o),
    .boosted_o       (boosted_o),
    .new_priority_o  (new_priority_o),
    .level_o         (level_o),
    .context_level_o (context_level_o)
  );

  `FPSS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
  `FPSS_ASSERT_NEXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `FPSS_ASSERT_IMPL(a_done_from_busy, done_o, $past(busy), "result without an item in work")
  `FPSS_ASSERT_IMPL(a_prio_range, done_o, new_priority_o >= 7'd100 && new_priority_o <= 7'd120,
                    "priority out of range")

endmodule

`default_nettype wire

### hw/rtl/fpss_ctrl.sv
// ----------------------------------------------------------------------------
// fpss_ctrl
// Sequencer: post-reset clearing pass, item fetch and the tick step chain.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire fpss_pkg::fpss_stat_t stat_i,
  output fpss_pkg::fpss_cmd_t     cmd_o
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_MUL2,
    ST_SUM,
    ST_MULDT,
    ST_LEVEL,
    ST_TOTAL,
    ST_DIV,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FETCH;
        end
      end
      ST_FETCH: begin
        if (stat_i.in_range && stat_i.opcode == fpss_pkg::OP_TICK && stat_i.active) begin
          cmd_o.mul1 = 1'b1;
          state_d    = ST_MUL2;
        end else begin
          cmd_o.fin_other = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = ST_MULDT;
      end
      ST_MULDT: begin
        cmd_o.muldt = 1'b1;
        state_d     = ST_LEVEL;
      end
      ST_LEVEL: begin
        cmd_o.lvl = 1'b1;
        state_d   = ST_TOTAL;
      end
      ST_TOTAL: begin
        cmd_o.total = 1'b1;
        state_d     = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div = 1'b1;
        state_d   = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.fin_tick = 1'b1;
        state_d        = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

`default_nettype wire

### hw/rtl/fpss_dp.sv
// ----------------------------------------------------------------------------
// fpss_dp
// Datapath: configuration registers, slot and history stores, level
// integration, history mean and decision.
// ----------------------------------------------------------------------------
`default_nettype none

module fpss_dp #(
  parameter int SLOTS       = fpss_pkg::SLOTS_DEFAULT,
  parameter int HISTORY_LEN = fpss_pkg::HISTORY_LEN_DEFAULT
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire fpss_pkg::fpss_cmd_t  cmd_i,
  output fpss_pkg::fpss_stat_t      stat_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [3:0]           slot_i,
  input  wire logic [9:0]           random_draw_i,
  input  wire logic                 task_running_i,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [2:0]           cfg_index_i,
  input  wire logic [16:0]          cfg_data_i,
  output logic                      done_o,
  output logic [3:0]                slot_out_o,
  output logic                      decided_o,
  output logic                      boosted_o,
  output logic [6:0]                new_priority_o,
  output logic [16:0]               level_o,
  output logic [16:0]               context_level_o
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int PW    = $clog2(HISTORY_LEN);
  localparam int FW    = $clog2(HISTORY_LEN + 1);
  localparam int TW    = $clog2(65536 * HISTORY_LEN + 1);
  localparam int DS    = TW + 6;
  localparam int HD    = SLOTS * (2 ** PW);
  localparam logic [DS-1:0] RECIP = DS'(((64'd1 << DS) / HISTORY_LEN) + 64'd1);
  localparam logic [TW-1:0] INIT_TOT = TW'(32768 * HISTORY_LEN);

  // configuration
  logic [16:0] prob_q, prio_q, alpha_q, beta_q, gamma_q, floor_q, dt_q;
  logic [16:0] prob_s, prio_s, alpha_s, beta_s, gamma_s, floor_s, dt_s;

  assign cfg_ready_o = 1'b1;
  assign prob_s  = fpss_pkg::q_sat(prob_q);
  assign prio_s  = fpss_pkg::q_sat(prio_q);
  assign alpha_s = fpss_pkg::q_sat(alpha_q);
  assign beta_s  = fpss_pkg::q_sat(beta_q);
  assign gamma_s = fpss_pkg::q_sat(gamma_q);
  assign floor_s = fpss_pkg::q_sat(floor_q);
  assign dt_s    = fpss_pkg::q_sat(dt_q);

  // slot stores
  logic          act_mem  [SLOTS];
  logic [16:0]   lvl_mem  [SLOTS];
  logic [16:0]   ctx_mem  [SLOTS];
  logic [PW-1:0] pos_mem  [SLOTS];
  logic [FW-1:0] fill_mem [SLOTS];
  logic [TW-1:0] tot_mem  [SLOTS];
  logic [16:0]   hist_mem [HD];

  // item registers
  logic [1:0]    op_q;
  logic [3:0]    slot_q;
  logic [SW-1:0] sidx_q;
  logic [9:0]    draw_q;
  logic          run_q;
  logic          inr_q;
  logic          act_r;
  logic [16:0]   lvl_r, ctx_r, hist_r;
  logic [PW-1:0] pos_r;
  logic [FW-1:0] fill_r;
  logic [TW-1:0] tot_r;

  logic [32:0]         p1_q, p2_q, p3_q, p4_q;
  logic signed [18:0]  s_q;
  logic signed [35:0]  prod_q;
  logic [16:0]         lv_q;
  logic [TW-1:0]       tot_q;
  logic [TW+DS-1:0]    quo_q;
  logic [SW-1:0]       clr_idx_q;

  logic [SW-1:0]       sidx;
  logic                in_range;
  logic signed [18:0]  s_d;
  logic signed [35:0]  prod_d;
  logic signed [20:0]  lvsum;
  logic [16:0]         lv_d;
  logic [16:0]         old_h;
  logic [TW-1:0]       tot_d;
  logic [16:0]         ctx_new;
  logic [PW-1:0]       pos_next;
  logic [FW-1:0]       fill_next;
  logic [16:0]         pmin, pdec;
  logic [26:0]         lhs, rhs;
  logic                dec_d;
  logic [21:0]         pr;
  logic [6:0]          npri;

  logic          mem_we;
  logic [SW-1:0] mem_addr;
  logic          w_act;
  logic [16:0]   w_lvl, w_ctx;
  logic [PW-1:0] w_pos;
  logic [FW-1:0] w_fill;
  logic [TW-1:0] w_tot;

  assign sidx     = SW'(slot_i);
  assign in_range = (32'(slot_i) < SLOTS);

  assign stat_o.opcode   = op_q;
  assign stat_o.in_range = inr_q;
  assign stat_o.active   = act_r;
  assign stat_o.clr_last = (clr_idx_q == SW'(SLOTS - 1));

  // integration
  assign s_d = $signed({2'b00, p4_q[32:16]}) - $signed({2'b00, p2_q[32:16]})
             + $signed({2'b00, p3_q[32:16]});
  assign prod_d = s_q * $signed({1'b0, dt_s});
  assign lvsum  = $signed({4'b0000, lvl_r}) + $signed({prod_q[35], prod_q[35:16]});

  always_comb begin
    if (lvsum < 0) begin
      lv_d = '0;
    end else if (lvsum > $signed({4'b0000, fpss_pkg::Q_ONE})) begin
      lv_d = fpss_pkg::Q_ONE;
    end else begin
      lv_d = lvsum[16:0];
    end
  end

  // history ring, running sum and mean
  assign old_h     = (FW'(pos_r) < fill_r) ? hist_r : fpss_pkg::Q_HALF;
  assign tot_d     = tot_r - TW'(old_h) + TW'(lv_q);
  assign ctx_new   = 17'(quo_q[TW+DS-1:DS]);
  assign pos_next  = ((PW+1)'(pos_r) + (PW+1)'(1) == (PW+1)'(HISTORY_LEN)) ? '0
                   : pos_r + PW'(1);
  assign fill_next = (fill_r < FW'(HISTORY_LEN)) ? fill_r + FW'(1) : fill_r;

  // decision and priority
  assign pmin  = (prob_s < lv_q) ? prob_s : lv_q;
  assign pdec  = (pmin < floor_s) ? floor_s : pmin;
  assign lhs   = 27'(pdec) * 27'd1000;
  assign rhs   = 27'({draw_q, 16'h0000});
  assign dec_d = (lhs > rhs);
  assign pr    = 22'(prio_s) * 22'd20;
  assign npri  = 7'd120 - 7'((pr + 22'd65535) >> 16);

  // slot store write port
  always_comb begin
    mem_we   = 1'b0;
    mem_addr = sidx_q;
    w_act    = act_r;
    w_lvl    = lvl_r;
    w_ctx    = ctx_r;
    w_pos    = pos_r;
    w_fill   = fill_r;
    w_tot    = tot_r;
    if (cmd_i.clr) begin
      mem_we   = 1'b1;
      mem_addr = clr_idx_q;
      w_act    = 1'b0;
      w_lvl    = fpss_pkg::Q_HALF;
      w_ctx    = '0;
      w_pos    = '0;
      w_fill   = '0;
      w_tot    = INIT_TOT;
    end else if (cmd_i.fin_tick) begin
      mem_we = 1'b1;
      w_act  = 1'b1;
      w_lvl  = lv_q;
      w_ctx  = ctx_new;
      w_pos  = pos_next;
      w_fill = fill_next;
      w_tot  = tot_q;
    end else if (cmd_i.fin_other && inr_q) begin
      if (op_q == fpss_pkg::OP_ACTIVATE) begin
        mem_we = 1'b1;
        w_act  = 1'b1;
        w_lvl  = fpss_pkg::Q_HALF;
        w_ctx  = '0;
        w_pos  = '0;
        w_fill = '0;
        w_tot  = INIT_TOT;
      end else if (op_q == fpss_pkg::OP_RETIRE) begin
        mem_we = 1'b1;
        w_act  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      act_mem[mem_addr]  <= w_act;
      lvl_mem[mem_addr]  <= w_lvl;
      ctx_mem[mem_addr]  <= w_ctx;
      pos_mem[mem_addr]  <= w_pos;
      fill_mem[mem_addr] <= w_fill;
      tot_mem[mem_addr]  <= w_tot;
    end
    if (cmd_i.load) begin
      act_r  <= act_mem[sidx];
      lvl_r  <= lvl_mem[sidx];
      ctx_r  <= ctx_mem[sidx];
      pos_r  <= pos_mem[sidx];
      fill_r <= fill_mem[sidx];
      tot_r  <= tot_mem[sidx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.total) begin
      hist_mem[{sidx_q, pos_r}] <= lv_q;
    end
    if (cmd_i.mul1) begin
      hist_r <= hist_mem[{sidx_q, pos_r}];
    end
  end

  // step registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= opcode_i;
      slot_q <= slot_i;
      sidx_q <= sidx;
      draw_q <= random_draw_i;
      run_q  <= task_running_i;
      inr_q  <= in_range;
    end
    if (cmd_i.mul1) begin
      p1_q <= 33'(alpha_s) * 33'(prob_s);
      p2_q <= 33'(beta_s) * 33'(lvl_r);
      p3_q <= 33'(gamma_s) * 33'(ctx_r);
    end
    if (cmd_i.mul2)  p4_q   <= 33'(p1_q[32:16]) * 33'(prio_s);
    if (cmd_i.sum)   s_q    <= s_d;
    if (cmd_i.muldt) prod_q <= prod_d;
    if (cmd_i.lvl)   lv_q   <= lv_d;
    if (cmd_i.total) tot_q  <= tot_d;
    if (cmd_i.div)   quo_q  <= (TW+DS)'(tot_q) * (TW+DS)'(RECIP);
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_tick) begin
      slot_out_o      <= slot_q;
      decided_o       <= dec_d;
      boosted_o       <= dec_d & run_q;
      new_priority_o  <= npri;
      level_o         <= lv_q;
      context_level_o <= ctx_new;
    end else if (cmd_i.fin_other) begin
      slot_out_o     <= slot_q;
      decided_o      <= 1'b0;
      boosted_o      <= 1'b0;
      new_priority_o <= npri;
      if (!inr_q) begin
        level_o         <= '0;
        context_level_o <= '0;
      end else if (op_q == fpss_pkg::OP_ACTIVATE) begin
        level_o         <= fpss_pkg::Q_HALF;
        context_level_o <= '0;
      end else begin
        level_o         <= lvl_r;
        context_level_o <= ctx_r;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_o    <= 1'b0;
      clr_idx_q <= '0;
      prob_q    <= fpss_pkg::RST_BASE_PROB;
      prio_q    <= fpss_pkg::RST_RUN_PRIO;
      alpha_q   <= fpss_pkg::RST_GAIN_INPUT;
      beta_q    <= fpss_pkg::RST_GAIN_DECAY;
      gamma_q   <= fpss_pkg::RST_GAIN_CONTEXT;
      floor_q   <= fpss_pkg::RST_FUZZ_FLOOR;
      dt_q      <= fpss_pkg::RST_TIME_STEP;
    end else begin
      done_o <= cmd_i.fin_tick | cmd_i.fin_other;
      if (cmd_i.clr) clr_idx_q <= clr_idx_q + SW'(1);
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          fpss_pkg::REG_BASE_PROB:    prob_q  <= cfg_data_i;
          fpss_pkg::REG_RUN_PRIO:     prio_q  <= cfg_data_i;
          fpss_pkg::REG_GAIN_INPUT:   alpha_q <= cfg_data_i;
          fpss_pkg::REG_GAIN_DECAY:   beta_q  <= cfg_data_i;
          fpss_pkg::REG_GAIN_CONTEXT: gamma_q <= cfg_data_i;
          fpss_pkg::REG_FUZZ_FLOOR:   floor_q <= cfg_data_i;
          fpss_pkg::REG_TIME_STEP:    dt_q    <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

### verif/fuzzy_process_state_scheduler_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fuzzy_process_state_scheduler_checker
// Watches the item, configuration and result channels of the scheduler. Keeps
// its own copy of the register file and of every slot's level, context and
// history ring, predicts each result in Q16 fixed point and compares it field
// by field against the strobed output.
// ----------------------------------------------------------------------------
module fuzzy_process_state_scheduler_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [3:0]  slot_i,
  input  logic [9:0]  random_draw_i,
  input  logic        task_running_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [16:0] cfg_data_i,
  input  logic        done_i,
  input  logic [3:0]  slot_out_i,
  input  logic        decided_i,
  input  logic        boosted_i,
  input  logic [6:0]  new_priority_i,
  input  logic [16:0] level_i,
  input  logic [16:0] context_level_i,
  output int          fail_count_o,
  output int          outstanding_o,
  output int          checked_o
);
  import fpss_pkg::*;

  localparam int NSLOT = SLOTS_DEFAULT;
  localparam int HLEN  = HISTORY_LEN_DEFAULT;

  typedef struct packed {
    logic [3:0]  slot;
    logic        decided;
    logic        boosted;
    logic [6:0]  prio_val;
    logic [16:0] level;
    logic [16:0] ctx_level;
  } sched_result_t;

  logic [16:0]   cfg_q [7];
  logic          slot_on [NSLOT];
  logic [16:0]   level_q [NSLOT];
  logic [16:0]   ctx_q [NSLOT];
  logic [16:0]   hist_q [NSLOT][HLEN];
  logic [3:0]    pos_q [NSLOT];
  logic [19:0]   total_q [NSLOT];
  sched_result_t pending_decisions [$];
  int            fails = 0;
  int            checked = 0;

  function automatic longint clipped_reg(input logic [2:0] idx);
    return (cfg_q[idx] > Q_ONE) ? longint'(Q_ONE) : longint'(cfg_q[idx]);
  endfunction

  task automatic clear_model();
    cfg_q[REG_BASE_PROB]    = RST_BASE_PROB;
    cfg_q[REG_RUN_PRIO]     = RST_RUN_PRIO;
    cfg_q[REG_GAIN_INPUT]   = RST_GAIN_INPUT;
    cfg_q[REG_GAIN_DECAY]   = RST_GAIN_DECAY;
    cfg_q[REG_GAIN_CONTEXT] = RST_GAIN_CONTEXT;
    cfg_q[REG_FUZZ_FLOOR]   = RST_FUZZ_FLOOR;
    cfg_q[REG_TIME_STEP]    = RST_TIME_STEP;
    for (int s = 0; s < NSLOT; s++) begin
      slot_on[s] = 1'b0;
      level_q[s] = Q_HALF;
      ctx_q[s]   = '0;
      pos_q[s]   = '0;
      total_q[s] = 20'(HLEN * 32768);
      for (int h = 0; h < HLEN; h++) hist_q[s][h] = '0;
    end
  endtask

  // Advance one slot by one item and return the result it produces.
  task automatic schedule_step(input logic [1:0] op, input logic [3:0] slot,
                               input logic [9:0] draw, input logic running,
                               output sched_result_t res);
    longint drive, decay, pull, rate, nxt, prob, chance;
    logic   pick;
    pick = 1'b0;
    res = '0;
    res.slot = slot;
    res.prio_val = 7'(120 - ((clipped_reg(REG_RUN_PRIO) * 20 + 65535) >> 16));
    case (op)
      OP_ACTIVATE: begin
        slot_on[slot] = 1'b1;
        level_q[slot] = Q_HALF;
        ctx_q[slot]   = '0;
        pos_q[slot]   = '0;
        total_q[slot] = 20'(HLEN * 32768);
        for (int h = 0; h < HLEN; h++) hist_q[slot][h] = Q_HALF;
      end
      OP_TICK: begin
        if (slot_on[slot]) begin
          drive = (((clipped_reg(REG_GAIN_INPUT) * clipped_reg(REG_BASE_PROB)) >> 16)
                   * clipped_reg(REG_RUN_PRIO)) >> 16;
          decay = (clipped_reg(REG_GAIN_DECAY) * longint'(level_q[slot])) >> 16;
          pull  = (clipped_reg(REG_GAIN_CONTEXT) * longint'(ctx_q[slot])) >> 16;
          rate  = (drive - decay + pull) * clipped_reg(REG_TIME_STEP);
          nxt   = longint'(level_q[slot]) + (rate >>> 16);
          if (nxt < 0) nxt = 0;
          if (nxt > longint'(Q_ONE)) nxt = longint'(Q_ONE);
          level_q[slot] = 17'(nxt);
          total_q[slot] = 20'(longint'(total_q[slot]) - longint'(hist_q[slot][pos_q[slot]])
                              + nxt);
          hist_q[slot][pos_q[slot]] = 17'(nxt);
          pos_q[slot] = (pos_q[slot] == 4'(HLEN - 1)) ? 4'd0 : pos_q[slot] + 4'd1;
          ctx_q[slot] = 17'(longint'(total_q[slot]) / HLEN);
          prob   = clipped_reg(REG_BASE_PROB);
          chance = (prob < nxt) ? prob : nxt;
          if (chance < clipped_reg(REG_FUZZ_FLOOR)) chance = clipped_reg(REG_FUZZ_FLOOR);
          pick = (chance * 1000 > longint'(draw) * 65536);
        end
      end
      OP_RETIRE: slot_on[slot] = 1'b0;
      default: ;
    endcase
    res.decided   = pick;
    res.boosted   = pick & running;
    res.level     = level_q[slot];
    res.ctx_level = ctx_q[slot];
  endtask

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t want;
    if (!rst_ni) begin
      clear_model();
      pending_decisions.delete();
      outstanding_o <= 0;
      fail_count_o  <= fails;
      checked_o     <= checked;
    end else begin
      if (done_i) begin
        if (pending_decisions.size() == 0) begin
          $error("result for slot %0d with no item outstanding", slot_out_i);
          fails++;
        end else begin
          want = pending_decisions.pop_front();
          check_field("slot_out", want.slot, slot_out_i);
          check_field("decided", want.decided, decided_i);
          check_field("boosted", want.boosted, boosted_i);
          check_field("new_priority", want.prio_val, new_priority_i);
          check_field("level", want.level, level_i);
          check_field("context_level", want.ctx_level, context_level_i);
          checked++;
        end
      end
      if (cfg_valid_i && cfg_ready_i && cfg_index_i <= REG_TIME_STEP) begin
        cfg_q[cfg_index_i] = cfg_data_i;
      end
      if (start && !busy) begin
        schedule_step(opcode_i, slot_i, random_draw_i, task_running_i, want);
        pending_decisions.push_back(want);
      end
      outstanding_o <= pending_decisions.size();
      fail_count_o  <= fails;
      checked_o     <= checked;
    end
  end

endmodule

### verif/tb_fuzzy_process_state_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fuzzy_process_state_scheduler
// Drives activate, tick, retire and unused-opcode commands into the scheduler
// across six register settings (reset values, full scale, zero, over range and
// random), with three sender idle profiles. A separate checker predicts and
// compares every result; this module builds the stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_fuzzy_process_state_scheduler;
  import fpss_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam logic [2:0] REG_UNMAPPED = 3'd7;
  localparam int         NUM_SETTINGS = 6;
  localparam int         ITEMS_PER_SETTING = 140;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [1:0]  opcode_i;
  logic [3:0]  slot_i;
  logic [9:0]  random_draw_i;
  logic        task_running_i;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [16:0] cfg_data_i;
  logic        done_o;
  logic [3:0]  slot_out_o;
  logic        decided_o;
  logic        boosted_o;
  logic [6:0]  new_priority_o;
  logic [16:0] level_o;
  logic [16:0] context_level_o;

  int          fail_count;
  int          outstanding;
  int          checked;
  int          idle_pct;
  int          sent;
  logic [3:0]  focus_slot;
  logic [16:0] cfg_plan [7];

  fuzzy_process_state_scheduler i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .random_draw_i  (random_draw_i),
    .task_running_i (task_running_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .slot_out_o     (slot_out_o),
    .decided_o      (decided_o),
    .boosted_o      (boosted_o),
    .new_priority_o (new_priority_o),
    .level_o        (level_o),
    .context_level_o(context_level_o)
  );

  fuzzy_process_state_scheduler_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .opcode_i       (opcode_i),
    .slot_i         (slot_i),
    .random_draw_i  (random_draw_i),
    .task_running_i (task_running_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .done_i         (done_o),
    .slot_out_i     (slot_out_o),
    .decided_i      (decided_o),
    .boosted_i      (boosted_o),
    .new_priority_i (new_priority_o),
    .level_i        (level_o),
    .context_level_i(context_level_o),
    .fail_count_o   (fail_count),
    .outstanding_o  (outstanding),
    .checked_o      (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("fuzzy_process_state_scheduler verification failed");
    $finish;
  end

  task automatic send_item(input logic [1:0] op, input logic [3:0] slot,
                           input logic [9:0] draw, input logic running);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start          <= 1'b1;
    opcode_i       <= op;
    slot_i         <= slot;
    random_draw_i  <= draw;
    task_running_i <= running;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent++;
  endtask

  // Hold the sender until every result is back.
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  task automatic load_registers(input logic with_unmapped);
    for (int r = 0; r <= REG_TIME_STEP; r++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(r);
      cfg_data_i  <= cfg_plan[r];
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    if (with_unmapped) begin
      cfg_index_i <= REG_UNMAPPED;
      cfg_data_i  <= 17'(($urandom));
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic plan_setting(input int setting);
    case (setting)
      0: begin
        cfg_plan[REG_BASE_PROB]    = RST_BASE_PROB;
        cfg_plan[REG_RUN_PRIO]     = RST_RUN_PRIO;
        cfg_plan[REG_GAIN_INPUT]   = RST_GAIN_INPUT;
        cfg_plan[REG_GAIN_DECAY]   = RST_GAIN_DECAY;
        cfg_plan[REG_GAIN_CONTEXT] = RST_GAIN_CONTEXT;
        cfg_plan[REG_FUZZ_FLOOR]   = RST_FUZZ_FLOOR;
        cfg_plan[REG_TIME_STEP]    = RST_TIME_STEP;
      end
      1: for (int r = 0; r <= REG_TIME_STEP; r++) cfg_plan[r] = Q_ONE;
      2: for (int r = 0; r <= REG_TIME_STEP; r++) cfg_plan[r] = '0;
      3: begin
        for (int r = 0; r <= REG_TIME_STEP; r++) cfg_plan[r] = 17'($urandom_range(65537, 131071));
        cfg_plan[REG_RUN_PRIO] = 17'h1FFFF;
      end
      default: begin
        for (int r = 0; r <= REG_TIME_STEP; r++) cfg_plan[r] = 17'($urandom_range(0, 65536));
        cfg_plan[REG_TIME_STEP] = 17'($urandom_range(0, 16384));
      end
    endcase
  endtask

  task automatic run_directed();
    send_item(OP_TICK, 4'd0, 10'd0, 1'b1);
    send_item(OP_RETIRE, 4'd15, 10'd999, 1'b0);
    send_item(OP_UNUSED, 4'd5, 10'd1023, 1'b1);
    send_item(OP_ACTIVATE, 4'd0, 10'd0, 1'b0);
    send_item(OP_ACTIVATE, 4'd15, 10'd1023, 1'b1);
    // wrap the history ring of slot 0
    for (int k = 0; k < 11; k++) begin
      send_item(OP_TICK, 4'd0, (k == 10) ? 10'd1023 : (k[0] ? 10'd999 : 10'd0), k[1]);
    end
    send_item(OP_TICK, 4'd15, 10'd0, 1'b1);
    send_item(OP_RETIRE, 4'd0, 10'd0, 1'b1);
    send_item(OP_TICK, 4'd0, 10'd0, 1'b1);
    send_item(OP_ACTIVATE, 4'd0, 10'd512, 1'b1);
    send_item(OP_TICK, 4'd0, 10'd512, 1'b1);
  endtask

  task automatic send_random();
    int         pick;
    logic [1:0] op;
    logic [3:0] slot;
    logic [9:0] draw;
    pick = $urandom_range(99);
    if (pick < 70) op = OP_TICK;
    else if (pick < 84) op = OP_ACTIVATE;
    else if (pick < 94) op = OP_RETIRE;
    else op = OP_UNUSED;
    if ($urandom_range(15) == 0) focus_slot = 4'($urandom);
    slot = ($urandom_range(1) == 1) ? focus_slot : 4'($urandom);
    draw = ($urandom_range(6) == 0) ? 10'($urandom) : 10'($urandom_range(0, 999));
    send_item(op, slot, draw, 1'($urandom));
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    opcode_i       <= OP_ACTIVATE;
    slot_i         <= '0;
    random_draw_i  <= '0;
    task_running_i <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= REG_BASE_PROB;
    cfg_data_i     <= '0;
    idle_pct   = 0;
    sent       = 0;
    focus_slot = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int setting = 0; setting < NUM_SETTINGS; setting++) begin
      plan_setting(setting);
      load_registers(setting == 4);
      idle_pct = (setting < 2) ? 18 : ((setting < 4) ? 68 : 0);
      if (setting == 0) run_directed();
      for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
        send_random();
        if ($urandom_range(199) == 0) wait_drained();
      end
      wait_drained();
    end
    repeat (20) @(posedge clk_i);
    $display("Checked %0d results from %0d commands over %0d register settings",
             checked, sent, NUM_SETTINGS);
    $display("(reset, full scale, zero, over range, random) and three sender idle profiles.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("fuzzy_process_state_scheduler verification clean");
    end else begin
      $display("fuzzy_process_state_scheduler verification failed");
    end
    $finish;
  end

endmodule

### fuzzy_process_state_scheduler.f
+incdir+hw/rtl
hw/rtl/fpss_pkg.sv
hw/rtl/fpss_ctrl.sv
hw/rtl/fpss_dp.sv
hw/rtl/fuzzy_process_state_scheduler.sv
verif/fuzzy_process_state_scheduler_checker.sv
verif/tb_fuzzy_process_state_scheduler.sv
